@@ src/ble_advertising_data_parser_defines.svh @@
// Assertion macros used by the checker of the advertising data parser.
`ifndef BLE_ADVERTISING_DATA_PARSER_DEFINES_SVH
`define BLE_ADVERTISING_DATA_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("advertising parser check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("advertising parser check failed");

`endif

@@ src/bap_pkg.sv @@
// Types, constants and the expected-name table of the advertising data parser.
package bap_pkg;

   // Position in the length-type-value walk.
   typedef enum logic [1:0] {
      PH_LENGTH,
      PH_TYPE,
      PH_VALUE,
      PH_STOPPED
   } phase_type;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN  = 2'd1;
   localparam logic [1:0] STATUS_ODD_LIST = 2'd2;

   // Advertising data structure types.
   localparam logic [7:0] AD_UUID16_PART = 8'h02;
   localparam logic [7:0] AD_UUID16_FULL = 8'h03;
   localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
   localparam logic [7:0] AD_NAME_FULL   = 8'h09;
   localparam logic [7:0] AD_SVC_DATA16  = 8'h16;
   localparam logic [7:0] AD_APPEARANCE  = 8'h19;

   // Byte values of the HID service UUID and the keyboard appearance.
   localparam logic [7:0] HID_UUID_LO   = 8'h12;
   localparam logic [7:0] HID_UUID_HI   = 8'h18;
   localparam logic [7:0] KBD_APPEAR_LO = 8'hC1;
   localparam logic [7:0] KBD_APPEAR_HI = 8'h03;

   // Expected name length and the stored-name limits.
   localparam logic [7:0] EXPECT_LEN   = 8'd19;
   localparam int         MAX_NAME_CAP = 31;
   localparam logic [7:0] PRINT_LO     = 8'd32;
   localparam logic [7:0] PRINT_HI     = 8'd126;
   localparam logic [6:0] SUBST_CHAR   = 7'h3F;

   // Bit positions in the flag vector.
   localparam int FLAG_HID  = 0;
   localparam int FLAG_KBD  = 1;
   localparam int FLAG_NAME = 2;

   // Outcome of one advertisement, as seen after its last byte.
   typedef struct packed {
      logic [1:0] status;
      logic       hid;
      logic       kbd;
      logic       name;
      logic [4:0] length;
   } summary_type;

   // Lower-case expected keyboard name, one character per index.
   function automatic logic [7:0] expected_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = 8'h65;
         5'd1:    c = 8'h77;
         5'd2:    c = 8'h69;
         5'd3:    c = 8'h6E;
         5'd4:    c = 8'h20;
         5'd5:    c = 8'h62;
         5'd6:    c = 8'h74;
         5'd7:    c = 8'h35;
         5'd8:    c = 8'h2E;
         5'd9:    c = 8'h31;
         5'd10:   c = 8'h20;
         5'd11:   c = 8'h6B;
         5'd12:   c = 8'h65;
         5'd13:   c = 8'h79;
         5'd14:   c = 8'h62;
         5'd15:   c = 8'h6F;
         5'd16:   c = 8'h61;
         5'd17:   c = 8'h72;
         5'd18:   c = 8'h64;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ src/bap_parse.sv @@
// Byte-by-byte walk of the length-type-value structures, with name store writes.
module bap_parse #(
   parameter int NAME_CAP = 31,
   parameter int IDX_W    = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_en,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output logic                 wr_en,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [6:0]           wr_data,
   output bap_pkg::summary_type summary
);

   localparam logic [6:0] SUBST_CHAR_W = bap_pkg::SUBST_CHAR;

   bap_pkg::phase_type phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] field_type_ff, field_type_in;
   logic [7:0] value_index_ff, value_index_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [2:0] flags_ff, flags_in;
   logic       match_ff, match_in;
   logic       copy_ff, copy_in;
   logic       odd_ff, odd_in;
   logic [4:0] stored_len_ff, stored_len_in;

   logic       end_req;
   logic [7:0] end_type;
   logic [7:0] n_left;
   logic [7:0] folded;
   logic       overrun;

   // Next parse state for one accepted beat.
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      field_type_in  = field_type_ff;
      value_index_in = value_index_ff;
      held_byte_in   = held_byte_ff;
      flags_in       = flags_ff;
      match_in       = match_ff;
      copy_in        = copy_ff;
      odd_in         = odd_ff;
      stored_len_in  = stored_len_ff;
      end_req        = 1'b0;
      end_type       = field_type_ff;
      n_left         = bytes_left_ff - 8'd1;
      wr_en          = 1'b0;
      wr_addr        = value_index_ff[IDX_W-1:0];
      wr_data        = SUBST_CHAR_W;
      folded         = (data_byte inside {[8'h41:8'h5A]}) ? data_byte + 8'd32 : data_byte;

      case (phase_ff)
         bap_pkg::PH_LENGTH: begin
            if (data_byte == 8'd0) begin
               phase_in = bap_pkg::PH_STOPPED;
            end else begin
               bytes_left_in = data_byte;
               phase_in      = bap_pkg::PH_TYPE;
            end
         end
         bap_pkg::PH_TYPE: begin
            // The type byte opens the value: set up the scan for this structure.
            field_type_in  = data_byte;
            bytes_left_in  = n_left;
            value_index_in = 8'd0;
            held_byte_in   = 8'd0;
            match_in       = 1'b0;
            copy_in        = 1'b0;
            if ((data_byte == bap_pkg::AD_UUID16_PART || data_byte == bap_pkg::AD_UUID16_FULL)
                && n_left[0]) begin
               odd_in = 1'b1;
            end else if (data_byte == bap_pkg::AD_SVC_DATA16 && n_left < 8'd2) begin
               field_type_in = 8'd0;
            end else if (data_byte == bap_pkg::AD_APPEARANCE && n_left != 8'd2) begin
               field_type_in = 8'd0;
            end else if (data_byte == bap_pkg::AD_NAME_SHORT
                         || data_byte == bap_pkg::AD_NAME_FULL) begin
               match_in = (n_left == bap_pkg::EXPECT_LEN);
               if (data_byte == bap_pkg::AD_NAME_FULL || stored_len_ff == 5'd0) begin
                  copy_in       = 1'b1;
                  stored_len_in = 5'd0;
               end
            end
            end_type = field_type_in;
            if (n_left == 8'd0) begin
               end_req = 1'b1;
            end else begin
               phase_in = bap_pkg::PH_VALUE;
            end
         end
         bap_pkg::PH_VALUE: begin
            // One value byte of the current structure.
            if (odd_ff) begin
               held_byte_in = held_byte_ff;
            end else if (field_type_ff == bap_pkg::AD_UUID16_PART
                         || field_type_ff == bap_pkg::AD_UUID16_FULL) begin
               if (!value_index_ff[0]) begin
                  held_byte_in = data_byte;
               end else if (held_byte_ff == bap_pkg::HID_UUID_LO
                            && data_byte == bap_pkg::HID_UUID_HI) begin
                  flags_in[bap_pkg::FLAG_HID] = 1'b1;
               end
            end else if (field_type_ff == bap_pkg::AD_SVC_DATA16) begin
               if (value_index_ff == 8'd0) begin
                  held_byte_in = data_byte;
               end else if (value_index_ff == 8'd1 && held_byte_ff == bap_pkg::HID_UUID_LO
                            && data_byte == bap_pkg::HID_UUID_HI) begin
                  flags_in[bap_pkg::FLAG_HID] = 1'b1;
               end
            end else if (field_type_ff == bap_pkg::AD_APPEARANCE) begin
               if (value_index_ff == 8'd0) begin
                  held_byte_in = data_byte;
               end else if (value_index_ff == 8'd1) begin
                  flags_in[bap_pkg::FLAG_KBD] = (held_byte_ff == bap_pkg::KBD_APPEAR_LO)
                                                && (data_byte == bap_pkg::KBD_APPEAR_HI);
               end
            end else if (field_type_ff == bap_pkg::AD_NAME_SHORT
                         || field_type_ff == bap_pkg::AD_NAME_FULL) begin
               if (match_ff && value_index_ff < bap_pkg::EXPECT_LEN
                   && folded != bap_pkg::expected_char(value_index_ff[4:0])) begin
                  match_in = 1'b0;
               end
               if (copy_ff && value_index_ff < 8'(NAME_CAP)) begin
                  wr_en         = 1'b1;
                  wr_data       = (data_byte inside {[bap_pkg::PRINT_LO:bap_pkg::PRINT_HI]})
                                  ? data_byte[6:0] : SUBST_CHAR_W;
                  stored_len_in = 5'(value_index_ff + 8'd1);
               end
            end
            value_index_in = value_index_ff + 8'd1;
            bytes_left_in  = n_left;
            if (n_left == 8'd0) begin
               end_req = 1'b1;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // Close of a structure: a surviving name match sets its flag.
      if (end_req) begin
         if ((end_type == bap_pkg::AD_NAME_SHORT || end_type == bap_pkg::AD_NAME_FULL)
             && !odd_in && match_in) begin
            flags_in[bap_pkg::FLAG_NAME] = 1'b1;
         end
         match_in = 1'b0;
         copy_in  = 1'b0;
         phase_in = odd_in ? bap_pkg::PH_STOPPED : bap_pkg::PH_LENGTH;
      end

      // Outcome as seen after this beat, used when it is the last one.
      overrun = (phase_in == bap_pkg::PH_TYPE) || (phase_in == bap_pkg::PH_VALUE);
      if (overrun) begin
         summary.status = bap_pkg::STATUS_OVERRUN;
      end else if (odd_in) begin
         summary.status = bap_pkg::STATUS_ODD_LIST;
      end else begin
         summary.status = bap_pkg::STATUS_OK;
      end
      summary.hid    = !overrun && flags_in[bap_pkg::FLAG_HID];
      summary.kbd    = !overrun && flags_in[bap_pkg::FLAG_KBD];
      summary.name   = !overrun && flags_in[bap_pkg::FLAG_NAME];
      summary.length = overrun ? 5'd0 : stored_len_in;
   end

   // Parse state registers; the last beat returns everything to its start.
   always_ff @(posedge clock) begin
      if (reset || (beat_en && last_byte)) begin
         phase_ff       <= bap_pkg::PH_LENGTH;
         bytes_left_ff  <= 8'd0;
         field_type_ff  <= 8'd0;
         value_index_ff <= 8'd0;
         held_byte_ff   <= 8'd0;
         flags_ff       <= 3'd0;
         match_ff       <= 1'b0;
         copy_ff        <= 1'b0;
         odd_ff         <= 1'b0;
         stored_len_ff  <= 5'd0;
      end else if (beat_en) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         field_type_ff  <= field_type_in;
         value_index_ff <= value_index_in;
         held_byte_ff   <= held_byte_in;
         flags_ff       <= flags_in;
         match_ff       <= match_in;
         copy_ff        <= copy_in;
         odd_ff         <= odd_in;
         stored_len_ff  <= stored_len_in;
      end
   end

endmodule

@@ src/ble_advertising_data_parser.sv @@
// Top level of the advertising data parser: structure walk, name store and result run.
// The last byte starts the run, which loads each result into the output register.
// Throughput: one byte per cycle while no run is active; a run of N results (N = name
// length, at least one) leaves at one per cycle from the name store's single read port
// unless the receiver stalls. Input is stalled from the last byte until the final
// result is loaded. Reset (synchronous, active high) restarts the parser.
module ble_advertising_data_parser #(
   parameter int NAME_SIZE = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_hid_seen,
   output logic       rsp_kbd_appearance,
   output logic       rsp_name_match,
   output logic       rsp_keyboard_candidate,
   output logic [4:0] rsp_name_length,
   output logic [6:0] rsp_name_char,
   output logic       rsp_last_result
);

   localparam int NAME_CAP = (NAME_SIZE - 1 > bap_pkg::MAX_NAME_CAP) ?
                             bap_pkg::MAX_NAME_CAP : NAME_SIZE - 1;
   localparam int IDX_W    = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;

   logic                 req_beat;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [6:0]           wr_data;
   bap_pkg::summary_type summary;

   bap_pkg::summary_type run_sum_ff;
   logic                 run_active_ff;
   logic [4:0]           run_k_ff;
   logic [4:0]           run_last_k;
   logic                 load;

   logic [6:0]           name_mem [NAME_CAP];
   logic [6:0]           char_ff;
   bap_pkg::summary_type rsp_sum_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_last_ff;

   // The store is written only while bytes flow and read only during a run,
   // so holding off input during the run keeps the two from overlapping.
   assign req_stall = run_active_ff;
   assign req_beat  = req_valid && !req_stall;

   bap_parse #(
      .NAME_CAP (NAME_CAP),
      .IDX_W    (IDX_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .beat_en   (req_beat),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .summary   (summary)
   );

   // Name store writes from the parser.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= wr_data;
      end
   end

   // During a run, a result is loaded whenever the output register is empty or being taken.
   assign load       = run_active_ff && (!rsp_valid_ff || !rsp_stall);
   assign run_last_k = (run_sum_ff.length == 5'd0) ? 5'd0 : run_sum_ff.length - 5'd1;

   // Run sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_k_ff      <= 5'd0;
      end else if (req_beat && req_last_byte) begin
         run_active_ff <= 1'b1;
         run_k_ff      <= 5'd0;
      end else if (load) begin
         run_active_ff <= (run_k_ff != run_last_k);
         run_k_ff      <= run_k_ff + 5'd1;
      end
   end

   // Outcome held for the length of the run.
   always_ff @(posedge clock) begin
      if (req_beat && req_last_byte) begin
         run_sum_ff <= summary;
      end
   end

   // Registered read of the store straight into the output beat.
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff     <= name_mem[run_k_ff[IDX_W-1:0]];
         rsp_sum_ff  <= run_sum_ff;
         rsp_last_ff <= (run_k_ff == run_last_k);
      end
   end

   // Output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_sum_ff.status;
   assign rsp_hid_seen           = rsp_sum_ff.hid;
   assign rsp_kbd_appearance     = rsp_sum_ff.kbd;
   assign rsp_name_match         = rsp_sum_ff.name;
   assign rsp_keyboard_candidate = rsp_sum_ff.hid | rsp_sum_ff.kbd | rsp_sum_ff.name;
   assign rsp_name_length        = rsp_sum_ff.length;
   assign rsp_name_char          = (rsp_sum_ff.length == 5'd0) ? 7'd0 : char_ff;
   assign rsp_last_result        = rsp_last_ff;

endmodule

@@ src/bap_checker.sv @@
// Port-level checks on the advertising data parser, bound to its top level.
`include "ble_advertising_data_parser_defines.svh"

module bap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_hid_seen,
   input logic       rsp_kbd_appearance,
   input logic       rsp_name_match,
   input logic       rsp_keyboard_candidate,
   input logic [4:0] rsp_name_length,
   input logic [6:0] rsp_name_char,
   input logic       rsp_last_result
);

   // A stalled beat keeps its character and its end-of-run mark.
   `BAP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_name_char) && $stable(rsp_last_result) && rsp_valid)

   // A run continues without a gap once a non-final beat is taken.
   `BAP_ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_last_result, rsp_valid)

   // Input is held off while a run is still being delivered.
   `BAP_ASSERT_NOW(a_busy_stall, clock, reset, rsp_valid && !rsp_last_result, req_stall)

   // An overrun clears every flag and the name.
   `BAP_ASSERT_NOW(a_overrun_clear, clock, reset, rsp_valid && rsp_status == bap_pkg::STATUS_OVERRUN, !rsp_keyboard_candidate && rsp_name_length == 5'd0 && !rsp_hid_seen && !rsp_name_match && !rsp_kbd_appearance)

endmodule

bind ble_advertising_data_parser bap_checker u_bap_checker (.*);
